// ===== rtl/rv32i_core_with_irq_timer_macros.svh =====
// assertion macros for the rv32i core with interrupt and timer unit
// used by the top level only, expects clock and reset in scope
`ifndef RV32I_CORE_WITH_IRQ_TIMER_MACROS_SVH
`define RV32I_CORE_WITH_IRQ_TIMER_MACROS_SVH

// same-cycle implication
`define RVC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("core assertion failed");

// next-cycle implication
`define RVC_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("core assertion failed");

`endif

// ===== rtl/rvc_pkg.sv =====
// shared types and constants of the rv32i core with interrupt and timer unit
// no dependencies
package rvc_pkg;

   localparam int unsigned MemWordsDef = 4096;
   localparam logic [31:0] RamBaseDef  = 32'h4000_0000;

   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_JAL    = 7'h6F;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_REG    = 7'h33;

   localparam logic [6:0] F7_ZERO = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   localparam logic [31:0] A_VECTOR   = 32'hF000_0000;
   localparam logic [31:0] A_CAUSE    = 32'hF000_0010;
   localparam logic [31:0] A_MASK     = 32'hF000_0020;
   localparam logic [31:0] A_STATUS   = 32'hF000_0030;
   localparam logic [31:0] A_EPC      = 32'hF000_0040;
   localparam logic [31:0] A_COUNTER  = 32'hF000_0050;
   localparam logic [31:0] A_COMPARE  = 32'hF000_0060;
   localparam logic [31:0] A_COMPARE2 = 32'hF000_0070;
   localparam logic [31:0] A_DEBUG    = 32'hF000_00D0;
   localparam logic [31:0] A_UART     = 32'hF000_00E0;
   localparam logic [31:0] A_DIVISOR  = 32'hF000_00F0;
   localparam logic [31:0] A_EXIT     = 32'hE000_0000;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_INVALID   = 3'd1;
   localparam logic [2:0] ST_UNALIGNED = 3'd2;
   localparam logic [2:0] ST_UNMAPPED  = 3'd3;
   localparam logic [2:0] ST_EXIT      = 3'd4;
   localparam logic [2:0] ST_HALTED    = 3'd5;

   localparam logic [2:0] COST_PLAIN = 3'd3;
   localparam logic [2:0] COST_MEM   = 3'd4;

   typedef struct packed {
      logic        wr;
      logic [31:0] val;
      logic [31:0] nxt;
      logic [2:0]  code;
      logic        ld;
      logic        st;
      logic [31:0] addr;
   } exe_type;

   typedef struct packed {
      logic [6:0]  pad;
      logic [7:0]  debug_byte;
      logic        debug_valid;
      logic [7:0]  uart_byte;
      logic        uart_valid;
      logic        irq_taken;
      logic [2:0]  step_cost;
      logic [2:0]  status_code;
      logic [31:0] exec_instr;
      logic [31:0] exec_pc;
   } rsp_type;

endpackage

// ===== rtl/rvc_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module rvc_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/rvc_exu.sv =====
// instruction decode and integer execute for the rv32i core
// depends on rvc_pkg
module rvc_exu import rvc_pkg::*; (
   input  logic [31:0] instr,
   input  logic [31:0] a,
   input  logic [31:0] b,
   input  logic [31:0] pc,
   input  logic [31:0] npc,
   output exe_type     ex
);

   logic [6:0]  op;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [4:0]  sh;
   logic [31:0] ii, is, ib, iu, ij;
   logic        tk;

   always_comb begin
      op = instr[6:0];
      f3 = instr[14:12];
      f7 = instr[31:25];
      sh = instr[24:20];
      ii = {{20{instr[31]}}, instr[31:20]};
      is = {{20{instr[31]}}, instr[31:25], instr[11:7]};
      ib = {{20{instr[31]}}, instr[7], instr[30:25], instr[11:8], 1'b0};
      iu = {instr[31:12], 12'b0};
      ij = {{12{instr[31]}}, instr[19:12], instr[20], instr[30:21], 1'b0};
      tk = 1'b0;
      ex = '0;
      ex.nxt = npc;
      case (op)
         OP_LUI: begin
            ex.wr = 1'b1;
            ex.val = iu;
         end
         OP_AUIPC: begin
            ex.wr = 1'b1;
            ex.val = pc + iu;
         end
         OP_JAL: begin
            ex.wr = 1'b1;
            ex.val = npc;
            ex.nxt = pc + ij;
         end
         OP_JALR: begin
            ex.wr = 1'b1;
            ex.val = npc;
            ex.nxt = (a + ii) & 32'hFFFF_FFFE;
         end
         OP_BRANCH: begin
            case (f3)
               3'd0: tk = (a == b);
               3'd1: tk = (a != b);
               3'd4: tk = ($signed(a) < $signed(b));
               3'd5: tk = !($signed(a) < $signed(b));
               3'd6: tk = (a < b);
               3'd7: tk = (a >= b);
               default: ex.code = ST_INVALID;
            endcase
            if (tk) begin
               ex.nxt = pc + ib;
            end
         end
         OP_LOAD: begin
            ex.wr = 1'b1;
            ex.ld = 1'b1;
            ex.addr = a + ii;
            if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) begin
               ex.code = ST_INVALID;
            end
         end
         OP_STORE: begin
            ex.st = 1'b1;
            ex.addr = a + is;
            if (f3 > 3'd2) begin
               ex.code = ST_INVALID;
            end
         end
         OP_IMM: begin
            ex.wr = 1'b1;
            case (f3)
               3'd0: ex.val = a + ii;
               3'd2: ex.val = {31'b0, $signed(a) < $signed(ii)};
               3'd3: ex.val = {31'b0, a < ii};
               3'd4: ex.val = a ^ ii;
               3'd6: ex.val = a | ii;
               3'd7: ex.val = a & ii;
               3'd1: ex.val = a << sh;
               3'd5: begin
                  if (f7 == F7_ZERO) ex.val = a >> sh;
                  else if (f7 == F7_ALT) ex.val = 32'($signed(a) >>> sh);
                  else ex.code = ST_INVALID;
               end
               default: ex.code = ST_INVALID;
            endcase
         end
         OP_REG: begin
            ex.wr = 1'b1;
            case (f3)
               3'd0: begin
                  if (f7 == F7_ZERO) ex.val = a + b;
                  else if (f7 == F7_ALT) ex.val = a - b;
                  else ex.code = ST_INVALID;
               end
               3'd1: ex.val = a << b[4:0];
               3'd2: ex.val = {31'b0, $signed(a) < $signed(b)};
               3'd3: ex.val = {31'b0, a < b};
               3'd4: ex.val = a ^ b;
               3'd5: begin
                  if (f7 == F7_ZERO) ex.val = a >> b[4:0];
                  else if (f7 == F7_ALT) ex.val = 32'($signed(a) >>> b[4:0]);
                  else ex.code = ST_INVALID;
               end
               3'd6: ex.val = a | b;
               3'd7: ex.val = a & b;
               default: ex.code = ST_INVALID;
            endcase
         end
         default: ex.code = ST_INVALID;
      endcase
   end

endmodule

// ===== rtl/rv32i_core_with_irq_timer.sv =====
// channel | dir | payload
// req_    | in  | tuser kind, tdata load_index and load_word
// rsp_    | out | tdata one result word per request word
// csr_    | in  | start address write
// execute word: fetch, register read and, for loads and stores, data access all go
// through the synchronous rams one after another; preload, halted or fetch-fault word:
// held in a pending register. a finished word waits in the output register
// while the next request is taken. reset is synchronous; main memory is not cleared.
// top level of the rv32i core with interrupt and timer unit
// depends on rvc_pkg, rvc_ram, rvc_exu and the assertion macro header
`include "rv32i_core_with_irq_timer_macros.svh"

module rv32i_core_with_irq_timer import rvc_pkg::*; #(
   parameter int unsigned MEM_WORDS = MemWordsDef,
   parameter logic [31:0] RAM_BASE  = RamBaseDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // load_index[11:0], load_word[43:12]
   input  logic        req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // exec_pc, exec_instr, status_code, step_cost, irq_taken, uart_valid,
   // uart_byte, debug_valid, debug_byte
   output logic [95:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   localparam int unsigned AW = $clog2(MEM_WORDS);
   localparam logic [32:0] RAM_LIMIT = {1'b0, RAM_BASE} + 33'(MEM_WORDS) * 33'd4;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FETCH = 3'd1;
   localparam logic [2:0] S_OPER  = 3'd2;
   localparam logic [2:0] S_MEMR  = 3'd3;
   localparam logic [2:0] S_PUSH  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [31:0]      pc_ff, npc_ff, vec_ff, cause_ff, mask_ff, ena_ff;
   logic [3:0][31:0] dly_ff;
   logic [31:0]      epc_ff, tick_ff, cmp1_ff, cmp2_ff;
   logic             halted_ff, irq_ff;
   logic [31:0]      instr_ff;
   logic [31:0]      reg_vld_ff;
   logic             vld1_ff, vld2_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff, pend_ff;

   logic        acc, out_free, irq_go, f_map, f_err;
   logic [31:0] fpc, foff, ld_ext;
   logic [11:0] ld_idx;
   logic [31:0] ld_word;

   logic          m_we, m_re;
   logic [AW-1:0] m_waddr, m_raddr;
   logic [31:0]   m_wdata, m_rdata;
   logic          r_we;
   logic [4:0]    rd;
   logic [31:0]   r1_rdata, r2_rdata, a, b;
   exe_type       ex;

   logic [31:0] doff, io_val, word, raw, ld_val, merged;
   logic [AW-1:0] didx, fidx;
   logic        d_map, io_rd, io_st, align_err;
   logic [2:0]  lsu_code, code_f;
   logic        do_commit, ok;

   logic [31:0]      c_in, e_in, tk_in, v1_in, v2_in, vc_in, mk_in, ep_in;
   logic [3:0][31:0] d_in;
   logic             uv_in, dv_in, exit_in;
   rsp_type          res;

   assign ld_idx   = req_tdata[11:0];
   assign ld_word  = req_tdata[43:12];
   assign ld_ext   = {20'b0, ld_idx};
   assign req_tready = (state_ff == S_IDLE);
   assign acc      = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign irq_go   = (ena_ff != 32'b0) && ((cause_ff & mask_ff) != 32'b0);
   assign fpc      = irq_go ? vec_ff : pc_ff;
   assign foff     = fpc - RAM_BASE;
   assign fidx     = foff[AW+1:2];
   assign f_map    = ({1'b0, fpc} >= {1'b0, RAM_BASE}) && ({1'b0, fpc} < RAM_LIMIT);
   assign f_err    = !f_map || (fpc[1:0] != 2'b00);

   assign a = vld1_ff ? r1_rdata : 32'b0;
   assign b = vld2_ff ? r2_rdata : 32'b0;
   assign rd = instr_ff[11:7];

   rvc_exu u_exu (
      .instr (instr_ff),
      .a     (a),
      .b     (b),
      .pc    (pc_ff),
      .npc   (npc_ff),
      .ex    (ex)
   );

   // data access
   assign doff  = ex.addr - RAM_BASE;
   assign didx  = doff[AW+1:2];
   assign d_map = ({1'b0, ex.addr} >= {1'b0, RAM_BASE}) && ({1'b0, ex.addr} < RAM_LIMIT);
   assign word  = m_rdata;

   always_comb begin
      io_rd = 1'b1;
      case (ex.addr)
         A_VECTOR:   io_val = vec_ff;
         A_CAUSE:    io_val = cause_ff | 32'h0000_00C0;
         A_MASK:     io_val = mask_ff;
         A_STATUS:   io_val = ena_ff;
         A_EPC:      io_val = epc_ff;
         A_COUNTER:  io_val = tick_ff;
         A_COMPARE:  io_val = cmp1_ff;
         A_COMPARE2: io_val = cmp2_ff;
         A_UART:     io_val = 32'b0;
         A_DIVISOR:  io_val = 32'b0;
         default: begin
            io_val = 32'b0;
            io_rd = 1'b0;
         end
      endcase
      case (ex.addr)
         A_STATUS, A_VECTOR, A_CAUSE, A_MASK, A_EPC, A_COUNTER, A_COMPARE,
         A_COMPARE2, A_EXIT, A_DEBUG, A_UART, A_DIVISOR: io_st = 1'b1;
         default: io_st = 1'b0;
      endcase
      align_err = ((instr_ff[13:12] == 2'd2) && (ex.addr[1:0] != 2'b00)) ||
                  ((instr_ff[13:12] == 2'd1) && ex.addr[0]);
      lsu_code = ST_OK;
      if (ex.ld && !io_rd) begin
         if (!d_map) lsu_code = ST_UNMAPPED;
         else if (align_err) lsu_code = ST_UNALIGNED;
      end
      if (ex.st && !io_st) begin
         if (!d_map) lsu_code = ST_UNMAPPED;
         else if (align_err) lsu_code = ST_UNALIGNED;
      end
      case (instr_ff[13:12])
         2'd0: raw = {24'b0, 8'(word >> {ex.addr[1:0], 3'b000})};
         2'd1: raw = {16'b0, ex.addr[1] ? word[31:16] : word[15:0]};
         default: raw = word;
      endcase
      if (io_rd) raw = io_val;
      case (instr_ff[14:12])
         3'd0: ld_val = {{24{raw[7]}}, raw[7:0]};
         3'd1: ld_val = {{16{raw[15]}}, raw[15:0]};
         3'd4: ld_val = {24'b0, raw[7:0]};
         3'd5: ld_val = {16'b0, raw[15:0]};
         default: ld_val = raw;
      endcase
      merged = word;
      case (instr_ff[13:12])
         2'd0: begin
            case (ex.addr[1:0])
               2'd0: merged[7:0]   = b[7:0];
               2'd1: merged[15:8]  = b[7:0];
               2'd2: merged[23:16] = b[7:0];
               default: merged[31:24] = b[7:0];
            endcase
         end
         2'd1: begin
            if (ex.addr[1]) merged[31:16] = b[15:0];
            else merged[15:0] = b[15:0];
         end
         default: merged = b;
      endcase
   end

   always_comb begin
      do_commit = out_free && ((state_ff == S_OPER && !(ex.ld || ex.st)) ||
                               state_ff == S_MEMR);
      code_f = (ex.code != ST_OK) ? ex.code : ((state_ff == S_MEMR) ? lsu_code : ST_OK);
      ok = do_commit && (code_f == ST_OK);
   end

   // interrupt and timer update of one completed instruction
   always_comb begin
      c_in = cause_ff; e_in = ena_ff; d_in = dly_ff; tk_in = tick_ff;
      v1_in = cmp1_ff; v2_in = cmp2_ff; vc_in = vec_ff; mk_in = mask_ff; ep_in = epc_ff;
      uv_in = 1'b0; dv_in = 1'b0; exit_in = 1'b0;
      if (ex.st && io_st) begin
         case (ex.addr)
            A_STATUS: begin
               if (b == 32'b0) begin
                  e_in = 32'b0;
                  d_in = '0;
               end else begin
                  d_in[3] = b;
               end
            end
            A_VECTOR:  vc_in = b;
            A_CAUSE:   c_in = b;
            A_MASK:    mk_in = b;
            A_EPC:     ep_in = b;
            A_COUNTER: tk_in = b;
            A_COMPARE: begin
               v1_in = b;
               c_in = c_in & 32'h0000_FFEF;
            end
            A_COMPARE2: begin
               v2_in = b;
               c_in = c_in & 32'h0000_FFDF;
            end
            A_EXIT:  exit_in = 1'b1;
            A_DEBUG: dv_in = 1'b1;
            A_UART:  uv_in = 1'b1;
            default: c_in = c_in;
         endcase
      end
      e_in = d_in[0];
      d_in[0] = d_in[1];
      d_in[1] = d_in[2];
      d_in[2] = d_in[3];
      tk_in = tk_in + 32'd1;
      if (v2_in[23:0] == tk_in[23:0]) c_in = c_in | 32'h20;
      if (v1_in == tk_in) c_in = c_in | 32'h10;
      if (!tk_in[16]) c_in = c_in | 32'h8; else c_in = c_in & 32'h0000_FFF7;
      if (tk_in[16]) c_in = c_in | 32'h4; else c_in = c_in & 32'h0000_FFFB;
      if (!tk_in[18]) c_in = c_in | 32'h2; else c_in = c_in & 32'h0000_FFFD;
      if (tk_in[18]) c_in = c_in | 32'h1; else c_in = c_in & 32'h0000_FFFE;
   end

   always_comb begin
      res = '0;
      res.exec_pc = pc_ff;
      res.exec_instr = instr_ff;
      res.step_cost = (ex.ld || ex.st) ? COST_MEM : COST_PLAIN;
      res.irq_taken = irq_ff;
      if (code_f != ST_OK) begin
         res.status_code = code_f;
      end else begin
         res.status_code = exit_in ? ST_EXIT : ST_OK;
         res.uart_valid = uv_in;
         res.uart_byte = uv_in ? b[7:0] : 8'b0;
         res.debug_valid = dv_in;
         res.debug_byte = dv_in ? b[7:0] : 8'b0;
      end
   end

   // memory ports
   always_comb begin
      m_we = 1'b0;
      m_waddr = didx;
      m_wdata = merged;
      m_re = 1'b0;
      m_raddr = fidx;
      if (state_ff == S_IDLE) begin
         m_waddr = ld_ext[AW-1:0];
         m_wdata = ld_word;
         m_we = acc && req_tuser && (ld_ext < 32'(MEM_WORDS));
         m_re = acc && !req_tuser && !halted_ff && !f_err;
      end else if (state_ff == S_OPER) begin
         m_raddr = didx;
         m_re = (ex.ld || ex.st) && d_map;
      end else if (state_ff == S_MEMR) begin
         m_we = ok && ex.st && !io_st;
      end
      r_we = ok && ex.wr && (rd != 5'd0);
   end

   rvc_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
      .clock (clock),
      .we    (m_we),
      .waddr (m_waddr),
      .wdata (m_wdata),
      .re    (m_re),
      .raddr (m_raddr),
      .rdata (m_rdata)
   );

   rvc_ram #(.WIDTH(32), .DEPTH(32)) u_rf1 (
      .clock (clock),
      .we    (r_we),
      .waddr (rd),
      .wdata (ex.ld ? ld_val : ex.val),
      .re    (state_ff == S_FETCH),
      .raddr (m_rdata[19:15]),
      .rdata (r1_rdata)
   );

   rvc_ram #(.WIDTH(32), .DEPTH(32)) u_rf2 (
      .clock (clock),
      .we    (r_we),
      .waddr (rd),
      .wdata (ex.ld ? ld_val : ex.val),
      .re    (state_ff == S_FETCH),
      .raddr (m_rdata[24:20]),
      .rdata (r2_rdata)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               if (req_tuser || halted_ff || f_err) state_in = S_PUSH;
               else state_in = S_FETCH;
            end
         end
         S_FETCH: state_in = S_OPER;
         S_OPER: begin
            if (ex.ld || ex.st) state_in = S_MEMR;
            else if (do_commit) state_in = S_IDLE;
         end
         S_MEMR: if (do_commit) state_in = S_IDLE;
         S_PUSH: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff <= RAM_BASE;
         npc_ff <= RAM_BASE + 32'd4;
         vec_ff <= '0; cause_ff <= '0; mask_ff <= '0; ena_ff <= '0; dly_ff <= '0;
         epc_ff <= '0; tick_ff <= '0; cmp1_ff <= '0; cmp2_ff <= '0;
         halted_ff <= 1'b0;
         irq_ff <= 1'b0;
         reg_vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            pc_ff <= csr_wdata;
            npc_ff <= csr_wdata + 32'd4;
         end
         if (acc) begin
            pend_ff <= '0;
            pend_ff.step_cost <= COST_PLAIN;
            if (!req_tuser && halted_ff) begin
               pend_ff.status_code <= ST_HALTED;
            end else if (!req_tuser) begin
               irq_ff <= irq_go;
               if (irq_go) begin
                  epc_ff <= npc_ff;
                  pc_ff <= vec_ff;
                  npc_ff <= vec_ff + 32'd4;
                  ena_ff <= '0;
                  dly_ff <= '0;
               end
               if (f_err) begin
                  halted_ff <= 1'b1;
                  pend_ff.exec_pc <= fpc;
                  pend_ff.irq_taken <= irq_go;
                  pend_ff.status_code <= f_map ? ST_UNALIGNED : ST_UNMAPPED;
               end
            end
         end
         if (state_ff == S_FETCH) begin
            instr_ff <= m_rdata;
            vld1_ff <= reg_vld_ff[m_rdata[19:15]];
            vld2_ff <= reg_vld_ff[m_rdata[24:20]];
         end
         if (do_commit && !ok) begin
            halted_ff <= 1'b1;
         end
         if (ok) begin
            pc_ff <= ex.nxt;
            npc_ff <= ex.nxt + 32'd4;
            cause_ff <= c_in; ena_ff <= e_in; dly_ff <= d_in; tick_ff <= tk_in;
            cmp1_ff <= v1_in; cmp2_ff <= v2_in; vec_ff <= vc_in; mask_ff <= mk_in;
            epc_ff <= ep_in;
            halted_ff <= exit_in;
         end
         if (r_we) begin
            reg_vld_ff[rd] <= 1'b1;
         end
         if (do_commit || (state_ff == S_PUSH && out_free)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_commit) begin
         rsp_data_ff <= res;
      end else if (state_ff == S_PUSH && out_free) begin
         rsp_data_ff <= pend_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `RVC_ASSERT_IMP(a_x0_never_valid, 1'b1, !reg_vld_ff[0])
   `RVC_ASSERT_NXT(a_halt_sticks, halted_ff && !csr_we, halted_ff)
   `RVC_ASSERT_NXT(a_memr_exit, state_ff == S_MEMR, state_ff == S_MEMR || state_ff == S_IDLE)
   `RVC_ASSERT_IMP(a_no_commit_busy_slot, do_commit, !rsp_valid_ff || rsp_tready)

endmodule
